// ===== hw/rtl/dips_pkg.sv =====
package dips_pkg;

	// ASCII codes the front end recognizes
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_K      = 8'h4B;
	localparam logic [7:0] CH_K_LC   = 8'h6B;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_M_LC   = 8'h6D;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_G_LC   = 8'h67;

	// APB register map (64-bit registers, byte address 8*i)
	localparam int          ADDR_W     = 4;
	localparam int          DATA_W     = 64;
	localparam logic        REG_MAXVAL = 1'b0;
	localparam logic        REG_SIGNED = 1'b1;
	localparam logic [63:0] MAXVAL_RST = 64'hFFFF_FFFF_FFFF_FFFF;

	// decoupling queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = 1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_CONV  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_NONE,
		K_DIGIT,
		K_SIGN,
		K_SUFFIX,
		K_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		SFX_K,
		SFX_M,
		SFX_G
	} sfx_t;

	// classified byte as it travels through the queue
	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       minus;
		sfx_t       sfx;
		logic       last;
	} ent_t;

	// end-of-string record handed from back end to finish stage
	typedef struct packed {
		logic [63:0] acc;
		logic        minus;
		status_t     err;
	} res_t;

endpackage

// ===== hw/rtl/dips_front.sv =====
module dips_front (
	input  logic               char_valid,
	output logic               char_ready,
	input  logic [7:0]         char_code,
	input  logic               last,
	input  logic               no_char,
	input  logic               signed_mode,
	input  logic               q_full,
	output logic               q_push,
	output dips_pkg::ent_t     q_ent
);

	assign char_ready = !q_full;

	// items with no byte and no end mark have no effect and are dropped here
	assign q_push = char_valid && char_ready && (!no_char || last);

	// byte classification
	always_comb begin
		q_ent.kind  = dips_pkg::K_OTHER;
		q_ent.digit = char_code[3:0];
		q_ent.minus = (char_code == dips_pkg::CH_MINUS);
		q_ent.sfx   = dips_pkg::SFX_K;
		q_ent.last  = last;
		if (no_char) begin
			q_ent.kind = dips_pkg::K_NONE;
		end else begin
			case (char_code) inside
				[dips_pkg::CH_0:dips_pkg::CH_9]: begin
					q_ent.kind = dips_pkg::K_DIGIT;
				end
				dips_pkg::CH_MINUS, dips_pkg::CH_PLUS: begin
					// a sign is only a sign in signed mode
					q_ent.kind = signed_mode ? dips_pkg::K_SIGN : dips_pkg::K_OTHER;
				end
				dips_pkg::CH_K, dips_pkg::CH_K_LC: begin
					q_ent.kind = dips_pkg::K_SUFFIX;
					q_ent.sfx  = dips_pkg::SFX_K;
				end
				dips_pkg::CH_M, dips_pkg::CH_M_LC: begin
					q_ent.kind = dips_pkg::K_SUFFIX;
					q_ent.sfx  = dips_pkg::SFX_M;
				end
				dips_pkg::CH_G, dips_pkg::CH_G_LC: begin
					q_ent.kind = dips_pkg::K_SUFFIX;
					q_ent.sfx  = dips_pkg::SFX_G;
				end
				default: begin
					q_ent.kind = dips_pkg::K_OTHER;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/dips_fifo.sv =====
module dips_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dips_pkg::ent_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output dips_pkg::ent_t rdata
);

	localparam logic [dips_pkg::QAW:0] CNT_FULL = (dips_pkg::QAW+1)'(dips_pkg::QDEPTH);

	dips_pkg::ent_t             slot_q [dips_pkg::QDEPTH];
	logic [dips_pkg::QAW-1:0]   wptr_q;
	logic [dips_pkg::QAW-1:0]   rptr_q;
	logic [dips_pkg::QAW:0]     cnt_q;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= wdata;
	end

endmodule

// ===== hw/rtl/dips_back.sv =====
module dips_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dips_pkg::ent_t q_ent,
	output logic           q_pop,
	output logic           res_valid,
	output dips_pkg::res_t res,
	input  logic           res_take
);

	typedef enum logic [1:0] {
		PH_START,
		PH_BODY,
		PH_SUFFIX
	} phase_t;

	logic [63:0]       acc_q;
	logic              minus_q;
	phase_t            phase_q;
	dips_pkg::status_t err_q;

	logic [63:0]       acc_n;
	logic              minus_n;
	phase_t            phase_n;
	dips_pkg::status_t err_n;

	logic [67:0]       dig_sum;
	logic              dig_ovf;
	logic [63:0]       sfx_val;
	logic              sfx_ovf;
	logic              s1_free;
	logic              res_vld_s1;
	dips_pkg::res_t    res_s1;

	// result stage can take a new record when empty or draining
	assign s1_free = !res_vld_s1 || res_take;
	assign q_pop   = !q_empty && (!q_ent.last || s1_free);

	// acc*10 + digit as shift-add, carry out of 64 bits is overflow
	assign dig_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, q_ent.digit};
	assign dig_ovf = |dig_sum[67:64];

	// binary suffix scaling
	always_comb begin
		case (q_ent.sfx)
			dips_pkg::SFX_K: begin
				sfx_ovf = |acc_q[63:54];
				sfx_val = {acc_q[53:0], 10'd0};
			end
			dips_pkg::SFX_M: begin
				sfx_ovf = |acc_q[63:44];
				sfx_val = {acc_q[43:0], 20'd0};
			end
			dips_pkg::SFX_G: begin
				sfx_ovf = |acc_q[63:34];
				sfx_val = {acc_q[33:0], 30'd0};
			end
			default: begin
				sfx_ovf = 1'b0;
				sfx_val = acc_q;
			end
		endcase
	end

	// parse step; first error wins
	always_comb begin
		acc_n   = acc_q;
		minus_n = minus_q;
		phase_n = phase_q;
		err_n   = err_q;
		if (q_ent.kind != dips_pkg::K_NONE && err_q == dips_pkg::ST_OK) begin
			if (phase_q == PH_SUFFIX) begin
				err_n = dips_pkg::ST_CONV;
			end else begin
				phase_n = PH_BODY;
				case (q_ent.kind)
					dips_pkg::K_SIGN: begin
						if (phase_q == PH_START) minus_n = q_ent.minus;
						else                     err_n   = dips_pkg::ST_CONV;
					end
					dips_pkg::K_DIGIT: begin
						if (dig_ovf) err_n = dips_pkg::ST_RANGE;
						else         acc_n = dig_sum[63:0];
					end
					dips_pkg::K_SUFFIX: begin
						if (sfx_ovf) begin
							err_n = dips_pkg::ST_RANGE;
						end else begin
							acc_n   = sfx_val;
							phase_n = PH_SUFFIX;
						end
					end
					default: begin
						err_n = dips_pkg::ST_CONV;
					end
				endcase
			end
		end
	end

	// string state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			minus_q <= 1'b0;
			phase_q <= PH_START;
			err_q   <= dips_pkg::ST_OK;
		end else if (q_pop) begin
			if (q_ent.last) begin
				acc_q   <= '0;
				minus_q <= 1'b0;
				phase_q <= PH_START;
				err_q   <= dips_pkg::ST_OK;
			end else begin
				acc_q   <= acc_n;
				minus_q <= minus_n;
				phase_q <= phase_n;
				err_q   <= err_n;
			end
		end
	end

	// end-of-string record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s1 <= 1'b0;
		end else if (q_pop && q_ent.last) begin
			res_vld_s1 <= 1'b1;
		end else if (res_take) begin
			res_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_ent.last) begin
			res_s1.acc   <= acc_n;
			res_s1.minus <= minus_n;
			res_s1.err   <= err_n;
		end
	end

	assign res_valid = res_vld_s1;
	assign res       = res_s1;

endmodule

// ===== hw/rtl/dips_finish.sv =====
module dips_finish (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	input  dips_pkg::res_t res,
	output logic           res_take,
	input  logic [63:0]    max_value,
	output logic           result_valid,
	input  logic           result_ready,
	output logic [63:0]    value,
	output logic           negative,
	output logic [1:0]     status
);

	logic              out_vld_q;
	logic [63:0]       value_q;
	logic              negative_q;
	dips_pkg::status_t status_q;
	dips_pkg::status_t st;

	assign res_take = res_valid && (!out_vld_q || result_ready);

	// limit check applies only when no earlier error was recorded
	always_comb begin
		st = res.err;
		if (res.err == dips_pkg::ST_OK && res.acc > max_value) st = dips_pkg::ST_RANGE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (result_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register; value and sign forced to zero on error
	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q   <= st;
			value_q    <= (st == dips_pkg::ST_OK) ? res.acc : 64'd0;
			negative_q <= (st == dips_pkg::ST_OK) && res.minus;
		end
	end

	assign result_valid = out_vld_q;
	assign value        = value_q;
	assign negative     = negative_q;
	assign status       = 2'(status_q);

endmodule

// ===== hw/rtl/decimal_integer_parser_with_suffix_core.sv =====
// Streaming ASCII decimal parser: one byte per transfer on the char channel, last marking the
// end of a string (no_char with last gives an empty string). An optional sign (signed mode),
// decimal digits and one K/M/G suffix (x2^10/2^20/2^30) yield one result transfer per string
// with magnitude, sign and status (ok, conversion error, out of range); value is zero on error.
// Sustained rate is one byte per cycle unless the result side stalls; the accumulate step
// (shift-add by ten plus digit with carry-out check) is combinational in the back end. The
// last byte passes the queue, the end-of-string record and the limit-compare output register
// to reach its result. Registers on the APB port: max_value at 0x0, signed_mode at 0x8 (bit 0).
module decimal_integer_parser_with_suffix_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dips_pkg::ADDR_W-1:0]   paddr,
	input  logic [dips_pkg::DATA_W-1:0]   pwdata,
	output logic [dips_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          char_valid,
	output logic                          char_ready,
	input  logic [7:0]                    char_code,
	input  logic                          last,
	input  logic                          no_char,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [63:0]                   value,
	output logic                          negative,
	output logic [1:0]                    status
);

	logic [63:0]    max_value_q;
	logic           signed_mode_q;
	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	dips_pkg::ent_t q_wdata;
	dips_pkg::ent_t q_rdata;
	logic           res_valid;
	logic           res_take;
	dips_pkg::res_t res;
	logic           reg_sel;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q   <= dips_pkg::MAXVAL_RST;
			signed_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == dips_pkg::REG_MAXVAL) max_value_q   <= pwdata;
			else                                 signed_mode_q <= pwdata[0];
		end
	end

	assign prdata = (reg_sel == dips_pkg::REG_MAXVAL) ? max_value_q
	                                                  : {63'd0, signed_mode_q};

	dips_front u_front (
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_code   (char_code),
		.last        (last),
		.no_char     (no_char),
		.signed_mode (signed_mode_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_ent       (q_wdata)
	);

	dips_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	dips_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_ent     (q_rdata),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	dips_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take),
		.max_value    (max_value_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.negative     (negative),
		.status       (status)
	);

`ifndef SYNTH
	// status code is always a defined one
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == 2'(dips_pkg::ST_OK) || status == 2'(dips_pkg::ST_CONV) ||
		                  status == 2'(dips_pkg::ST_RANGE)))
		else $error("illegal status code");

	// any error forces value and sign to zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != 2'(dips_pkg::ST_OK)) |-> (value == 64'd0 && !negative))
		else $error("nonzero result on error");

	// an ok result never exceeds the configured limit
	a_ok_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == 2'(dips_pkg::ST_OK)) |-> (value <= max_value_q))
		else $error("ok result above max_value");

	// the queue never takes a push while full
	a_q_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue overflow");
`endif

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 175;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;
	localparam logic [dips_pkg::ADDR_W-1:0] MAXVAL_ADDR = 4'h0;
	localparam logic [dips_pkg::ADDR_W-1:0] SIGNED_ADDR = 4'h8;

	typedef enum logic [1:0] {
		PHASE_START,
		PHASE_BODY,
		PHASE_SUFFIX
	} phase_t;

	typedef struct {
		logic [63:0]       magnitude;
		logic              minus;
		dips_pkg::status_t code;
	} number_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
		logic       none;
	} char_item_t;

	// Tracks the parse of the current string and holds the numbers still owed by the block
	class number_scoreboard;
		number_t           expected_numbers[$];
		logic [63:0]       limit_value;
		logic              sign_enable;
		logic [63:0]       acc;
		logic              minus;
		phase_t            phase;
		dips_pkg::status_t err;
		int                mismatches;
		int                failures;

		function new();
			limit_value = dips_pkg::MAXVAL_RST;
			sign_enable = 1'b1;
			mismatches = 0;
			failures = 0;
			restart();
		endfunction

		function void restart();
			acc = '0;
			minus = 1'b0;
			phase = PHASE_START;
			err = dips_pkg::ST_OK;
		endfunction

		function void take_byte(logic [7:0] c);
			logic [67:0] wide;
			int          sh;
			// first error wins; later bytes are dropped
			if (err != dips_pkg::ST_OK)
				return;
			if (phase == PHASE_SUFFIX) begin
				err = dips_pkg::ST_CONV;
				return;
			end
			if (phase == PHASE_START) begin
				phase = PHASE_BODY;
				if (sign_enable && (c == dips_pkg::CH_MINUS || c == dips_pkg::CH_PLUS)) begin
					minus = (c == dips_pkg::CH_MINUS);
					return;
				end
			end
			// digit: acc*10 + d, checked against 64-bit overflow
			if (c >= dips_pkg::CH_0 && c <= dips_pkg::CH_9) begin
				wide = {4'b0, acc} * 68'd10 + {60'b0, c - dips_pkg::CH_0};
				if (wide[67:64] != 4'b0)
					err = dips_pkg::ST_RANGE;
				else
					acc = wide[63:0];
				return;
			end
			case (c)
				dips_pkg::CH_K, dips_pkg::CH_K_LC: sh = 10;
				dips_pkg::CH_M, dips_pkg::CH_M_LC: sh = 20;
				dips_pkg::CH_G, dips_pkg::CH_G_LC: sh = 30;
				default:                           sh = 0;
			endcase
			if (sh != 0) begin
				if ((acc >> (64 - sh)) != 64'd0) begin
					err = dips_pkg::ST_RANGE;
				end else begin
					acc = acc << sh;
					phase = PHASE_SUFFIX;
				end
				return;
			end
			err = dips_pkg::ST_CONV;
		endfunction

		function void note_char(logic [7:0] c, logic is_last, logic none);
			number_t n;
			if (!none)
				take_byte(c);
			if (!is_last)
				return;
			n.code = err;
			if (n.code == dips_pkg::ST_OK && acc > limit_value)
				n.code = dips_pkg::ST_RANGE;
			n.magnitude = (n.code == dips_pkg::ST_OK) ? acc : 64'd0;
			n.minus = (n.code == dips_pkg::ST_OK) ? minus : 1'b0;
			expected_numbers.push_back(n);
			restart();
		endfunction

		function void check_number(logic [63:0] v, logic neg, logic [1:0] st);
			number_t n;
			if (expected_numbers.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: value %0d negative %0b status %0d",
						v, neg, st);
				return;
			end
			n = expected_numbers.pop_front();
			if (v !== n.magnitude || neg !== n.minus || st !== n.code) begin
				failures++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"mismatch: expected value %0d negative %0b status %0d, ",
						"got value %0d negative %0b status %0d"},
						n.magnitude, n.minus, n.code, v, neg, st);
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [dips_pkg::ADDR_W-1:0] paddr;
	logic [dips_pkg::DATA_W-1:0] pwdata;
	logic [dips_pkg::DATA_W-1:0] prdata;
	logic                        pready;
	logic                        char_valid;
	logic                        char_ready;
	logic [7:0]                  char_code;
	logic                        last;
	logic                        no_char;
	logic                        result_valid;
	logic                        result_ready;
	logic [63:0]                 value;
	logic                        negative;
	logic [1:0]                  status;

	number_scoreboard sb;
	char_item_t       text_q[$];
	int               burst_left;
	int               items_sent;
	logic             hold_off_req;

	decimal_integer_parser_with_suffix_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// APB write: setup cycle, then access cycle until pready
	task automatic write_register(logic [dips_pkg::ADDR_W-1:0] addr,
		logic [dips_pkg::DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop offering and wait until every owed number has arrived
	task automatic await_drain();
		@(negedge clk);
		char_valid <= 1'b0;
		while (sb.expected_numbers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [63:0] limit, logic sign_on);
		await_drain();
		write_register(MAXVAL_ADDR, limit);
		write_register(SIGNED_ADDR, {63'b0, sign_on});
		sb.limit_value = limit;
		sb.sign_enable = sign_on;
	endtask

	// one char transfer; bursts of random length separated by random gaps
	task automatic offer_char(char_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				char_valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		char_valid <= 1'b1;
		char_code <= it.code;
		last <= it.last;
		no_char <= it.none;
		do @(posedge clk); while (!(char_valid && char_ready));
		sb.note_char(it.code, it.last, it.none);
		items_sent++;
	endtask

	function automatic void add_char(logic [7:0] c, logic none);
		char_item_t it;
		it.code = c;
		it.last = 1'b0;
		it.none = none;
		text_q.push_back(it);
	endfunction

	function automatic logic [7:0] digit_char();
		return dips_pkg::CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] any_suffix();
		case ($urandom_range(0, 5))
			0:       return dips_pkg::CH_K;
			1:       return dips_pkg::CH_K_LC;
			2:       return dips_pkg::CH_M;
			3:       return dips_pkg::CH_M_LC;
			4:       return dips_pkg::CH_G;
			default: return dips_pkg::CH_G_LC;
		endcase
	endfunction

	function automatic logic [7:0] any_sign();
		return ($urandom_range(0, 1) == 0) ? dips_pkg::CH_MINUS : dips_pkg::CH_PLUS;
	endfunction

	// well-formed string: optional sign, digits, optional suffix
	function automatic void compose_number();
		int    sel;
		int    count;
		string near_max;
		near_max = "1844674407370955161";
		sel = $urandom_range(0, 99);
		if (sel < 20)
			add_char(dips_pkg::CH_MINUS, 1'b0);
		else if (sel < 40)
			add_char(dips_pkg::CH_PLUS, 1'b0);
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			count = 0;
		end else if (sel < 50) begin
			count = $urandom_range(1, 5);
		end else if (sel < 80) begin
			count = $urandom_range(6, 19);
		end else if (sel < 92) begin
			// sits right at the 64-bit boundary
			for (int i = 0; i < near_max.len(); i++)
				add_char(near_max[i], 1'b0);
			count = 1;
		end else begin
			count = $urandom_range(20, 22);
		end
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 6)
				add_char(8'($urandom), 1'b1);
			add_char(digit_char(), 1'b0);
		end
		if ($urandom_range(0, 99) < 35)
			add_char(any_suffix(), 1'b0);
	endfunction

	function automatic void compose_noise();
		int count;
		int sel;
		count = $urandom_range(1, 6);
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 40)
				add_char(8'($urandom), 1'b0);
			else if (sel < 60)
				add_char(digit_char(), 1'b0);
			else if (sel < 75)
				add_char(any_sign(), 1'b0);
			else if (sel < 90)
				add_char(any_suffix(), 1'b0);
			else
				add_char(8'($urandom), 1'b1);
		end
	endfunction

	// mark the end of the string, then send it
	task automatic send_string();
		char_item_t tail;
		if (text_q.size() == 0 || $urandom_range(0, 99) < 15) begin
			tail.code = 8'($urandom);
			tail.last = 1'b1;
			tail.none = 1'b1;
			text_q.push_back(tail);
		end else begin
			text_q[text_q.size() - 1].last = 1'b1;
		end
		foreach (text_q[i])
			offer_char(text_q[i]);
		text_q.delete();
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], 1'b0);
		send_string();
	endtask

	// result side: long hold-off on request, otherwise a changing stall pattern
	initial begin
		logic rdy;
		int   hold_left;
		int   stall_left;
		int   stall_mode;
		int   rx_tick;
		hold_left = 0;
		stall_left = 0;
		stall_mode = 0;
		rx_tick = 0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (stall_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					stall_left = $urandom_range(16, 80);
				end
				stall_left--;
				case (stall_mode)
					0:       rdy = 1'b1;
					1:       rdy = 1'($urandom_range(0, 1));
					2:       rdy = (rx_tick % 4) != 0;
					default: rdy = $urandom_range(0, 9) != 0;
				endcase
			end
			result_ready <= rdy;
		end
	end

	// result monitor and watchdog on cycles without any transfer
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n) begin
				if (result_valid && result_ready)
					sb.check_number(value, negative, status);
				if ((char_valid && char_ready) || (result_valid && result_ready))
					idle = 0;
				else
					idle++;
			end
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int phase_start;
		int sel;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		char_valid = 1'b0;
		char_code = '0;
		last = 1'b0;
		no_char = 1'b0;
		result_ready = 1'b0;
		hold_off_req = 1'b0;
		burst_left = 0;
		items_sent = 0;
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed strings under reset settings
		configure(dips_pkg::MAXVAL_RST, 1'b1);
		send_string();
		send_text("-");
		send_text("+");
		send_text("k");
		send_text("9");
		send_text("-7");
		send_text("3M");
		send_text("1g");
		send_text("2K5");
		send_text("1-");
		send_text("0");
		add_char(8'hFF, 1'b0);
		send_string();

		// unsigned mode and a small limit
		configure(64'd100, 1'b0);
		send_text("-1");
		send_text("101");
		send_text("100");

		// random strings over several register settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0:       configure(dips_pkg::MAXVAL_RST, 1'b1);
				1:       configure(64'd0, 1'b0);
				2:       configure({$urandom, $urandom}, 1'b1);
				3:       configure(64'($urandom_range(0, 100000)), 1'b0);
				4:       configure({24'd0, 8'($urandom), $urandom}, 1'b1);
				default: configure(dips_pkg::MAXVAL_RST - 64'($urandom_range(0, 1000)), 1'b0);
			endcase
			// let the char side back up behind a stalled result side
			if (p == 2)
				hold_off_req = 1'b1;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				sel = $urandom_range(0, 99);
				if (sel < 70) begin
					compose_number();
				end else if (sel < 85) begin
					compose_noise();
				end else begin
					compose_number();
					case ($urandom_range(0, 3))
						0:       add_char(digit_char(), 1'b0);
						1:       add_char(any_sign(), 1'b0);
						2:       add_char(any_suffix(), 1'b0);
						default: add_char(8'($urandom), 1'b0);
					endcase
				end
				send_string();
			end
		end

		await_drain();
		if (sb.failures == 0 && sb.expected_numbers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
